// ===== hw/rtl/dbfir_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbfir_pkg
// Shared constants, coefficient tables and control types for the dual-band
// 21-tap lowpass FIR.
// ----------------------------------------------------------------------------
package dbfir_pkg;

  // Filter geometry
  localparam int TAP_COUNT = 21;
  localparam int HALF_TAPS = 11;
  localparam int HIST_LEN  = TAP_COUNT - 1;

  // Field widths
  localparam int SAMPLE_W = 8;
  localparam int X_W      = 9;
  localparam int OUT_W    = 25;

  // Mid-scale offset of the ADC
  localparam int ADC_OFFSET = 127;

  // Default coefficient fraction bits (Q1.15)
  localparam int COEF_FRACTION_BITS_DEF = 15;

  // Decimal tables are scaled by 10^17 = 5^17 * 2^17
  localparam int              DEC_SHIFT = 17;
  localparam longint unsigned FIVE_POW  = 64'd762939453125;

  // First half of each symmetric table (taps 0..10), value times 10^17
  localparam longint TAPS_NORMAL [HALF_TAPS] = '{
    64'sd0, -64'sd213260700731174, 64'sd635615965165261, -64'sd1166836207173410,
    64'sd1241482624423060, 64'sd0, -64'sd3192924532037980, 64'sd8183251570581010,
    -64'sd13816340220317400, 64'sd18301247568109800, 64'sd80055527863961700
  };
  localparam longint TAPS_ALERT [HALF_TAPS] = '{
    64'sd0, -64'sd212227114882539, -64'sd632535399151418, -64'sd1161181037762100,
    -64'sd1235465674898240, 64'sd0, 64'sd3177449755856730, 64'sd8143590756421770,
    64'sd13749378170194300, 64'sd18212549038873500, 64'sd19916883010696000
  };

  // Control from the top level to the multiply-accumulate datapath
  typedef struct packed {
    logic load;
    logic band;
  } mac_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dbfir_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbfir_mac
// Folded symmetric multiply stage with product registers, followed by the
// combinational sum of the eleven registered products.
// ----------------------------------------------------------------------------
module dbfir_mac #(
  parameter int COEF_FRACTION_BITS = dbfir_pkg::COEF_FRACTION_BITS_DEF,
  localparam int ACC_W = COEF_FRACTION_BITS + 16
) (
  input  wire logic                       clk,
  input  wire dbfir_pkg::mac_ctrl_t       ctrl,
  input  wire logic signed [dbfir_pkg::X_W-1:0] taps [dbfir_pkg::TAP_COUNT],
  output logic signed [ACC_W-1:0]         acc
);

  localparam int COEF_W = COEF_FRACTION_BITS + 2;
  localparam int PAIR_W = dbfir_pkg::X_W + 1;
  localparam int PROD_W = PAIR_W + COEF_W;
  localparam int HALF   = dbfir_pkg::HALF_TAPS;
  localparam int SPLIT  = HALF / 2;
  localparam int UP_SH  = (COEF_FRACTION_BITS >= dbfir_pkg::DEC_SHIFT) ?
                          COEF_FRACTION_BITS - dbfir_pkg::DEC_SHIFT : 0;
  localparam int DN_SH  = (COEF_FRACTION_BITS < dbfir_pkg::DEC_SHIFT) ?
                          dbfir_pkg::DEC_SHIFT - COEF_FRACTION_BITS : 0;

  logic signed [COEF_W-1:0] coef_norm [HALF];
  logic signed [COEF_W-1:0] coef_alt  [HALF];
  logic signed [PAIR_W-1:0] pair      [HALF];
  logic signed [PROD_W-1:0] prod_nxt  [HALF];
  logic signed [PROD_W-1:0] prod_r    [HALF];

  // Build fixed-point coefficients, round to nearest with ties away from zero
  for (genvar i = 0; i < HALF; i++) begin : g_coef
    localparam longint          DEC_N = dbfir_pkg::TAPS_NORMAL[i];
    localparam longint          DEC_A = dbfir_pkg::TAPS_ALERT[i];
    localparam longint unsigned MAG_N = (DEC_N < 0) ? -DEC_N : DEC_N;
    localparam longint unsigned MAG_A = (DEC_A < 0) ? -DEC_A : DEC_A;
    localparam longint unsigned DEN   = dbfir_pkg::FIVE_POW << DN_SH;
    localparam longint unsigned NUM_N = MAG_N << UP_SH;
    localparam longint unsigned NUM_A = MAG_A << UP_SH;
    localparam longint unsigned Q_N   = (2 * NUM_N + DEN) / (2 * DEN);
    localparam longint unsigned Q_A   = (2 * NUM_A + DEN) / (2 * DEN);
    localparam longint          C_N   = (DEC_N < 0) ? -longint'(Q_N) : longint'(Q_N);
    localparam longint          C_A   = (DEC_A < 0) ? -longint'(Q_A) : longint'(Q_A);
    assign coef_norm[i] = COEF_W'(C_N);
    assign coef_alt[i]  = COEF_W'(C_A);
  end

  // Fold mirrored taps, pass the center tap alone
  for (genvar i = 0; i < HALF; i++) begin : g_pair
    if (i == HALF - 1) begin : g_center
      assign pair[i] = PAIR_W'(taps[i]);
    end else begin : g_fold
      assign pair[i] = PAIR_W'(taps[i]) + PAIR_W'(taps[dbfir_pkg::TAP_COUNT - 1 - i]);
    end
  end

  // Multiply each folded pair by the selected band coefficient
  always_comb begin
    for (int i = 0; i < HALF; i++) begin
      prod_nxt[i] = PROD_W'(pair[i]) *
                    PROD_W'(ctrl.band ? coef_alt[i] : coef_norm[i]);
    end
  end

  // Hold products until the next transfer into this stage
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < HALF; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
  end

  // Sum products in two halves, then combine
  always_comb begin
    logic signed [ACC_W-1:0] sum_lo;
    logic signed [ACC_W-1:0] sum_hi;
    sum_lo = '0;
    sum_hi = '0;
    for (int i = 0; i < SPLIT; i++) begin
      sum_lo = sum_lo + ACC_W'(prod_r[i]);
    end
    for (int i = SPLIT; i < HALF; i++) begin
      sum_hi = sum_hi + ACC_W'(prod_r[i]);
    end
    acc = sum_lo + sum_hi;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dual_band_fir_lowpass_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_band_fir_lowpass_top
// Offset removal, 21-tap symmetric lowpass FIR with two selectable
// coefficient tables, and a capture-start clear of the delay line.
// ----------------------------------------------------------------------------
// Pipeline: an input transfer passes through the product register, then the
//   result register, before out_valid.
// Throughput: one sample per cycle; the two-stage pipeline stalls only while
//   a finished result waits on out_ready.
// Reset (synchronous, rst_n low): delay line cleared, band_select set to 0,
//   pipeline emptied.
module dual_band_fir_lowpass_top #(
  parameter int COEF_FRACTION_BITS = dbfir_pkg::COEF_FRACTION_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dbfir_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                          in_capture_start,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [dbfir_pkg::OUT_W-1:0] out_filtered
);

  localparam int X_W   = dbfir_pkg::X_W;
  localparam int HIST  = dbfir_pkg::HIST_LEN;
  localparam int TAPS  = dbfir_pkg::TAP_COUNT;
  localparam int OUT_W = dbfir_pkg::OUT_W;
  localparam int ACC_W = COEF_FRACTION_BITS + 16;
  localparam int SAT_W = (ACC_W > OUT_W) ? ACC_W : OUT_W;
  localparam logic signed [SAT_W-1:0] SAT_MAX =
    {{(SAT_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_MIN =
    {{(SAT_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

  logic                    band_select_r;
  logic                    s1_valid_r;
  logic                    s1_valid_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [OUT_W-1:0] out_filtered_r;
  logic signed [OUT_W-1:0] out_filtered_nxt;
  logic                    advance;
  logic                    in_fire;
  logic signed [X_W-1:0]   x;
  logic signed [X_W-1:0]   dly_r   [HIST];
  logic signed [X_W-1:0]   dly_nxt [HIST];
  logic signed [X_W-1:0]   taps    [TAPS];
  logic signed [ACC_W-1:0] acc;
  dbfir_pkg::mac_ctrl_t    mac_ctrl;

  // Handshake: downstream stage frees when empty or its result is taken
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_filtered = out_filtered_r;

  // Remove the mid-scale offset
  assign x = $signed({1'b0, in_sample}) - X_W'(dbfir_pkg::ADC_OFFSET);

  // Form the tap vector and the next delay line; drop history on capture start
  always_comb begin
    taps[0] = x;
    for (int k = 1; k < TAPS; k++) begin
      taps[k] = in_capture_start ? '0 : dly_r[k - 1];
    end
    for (int k = 0; k < HIST; k++) begin
      dly_nxt[k] = taps[k];
    end
  end

  // Advance the delay line on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HIST; k++) begin
        dly_r[k] <= '0;
      end
    end else if (in_fire) begin
      for (int k = 0; k < HIST; k++) begin
        dly_r[k] <= dly_nxt[k];
      end
    end
  end

  // Band select register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_select_r <= 1'b0;
    end else if (cfg_wr_en) begin
      band_select_r <= cfg_wr_data;
    end
  end

  assign mac_ctrl.load = in_fire;
  assign mac_ctrl.band = band_select_r;

  dbfir_mac #(
    .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
  ) u_mac (
    .clk (clk),
    .ctrl(mac_ctrl),
    .taps(taps),
    .acc (acc)
  );

  // Saturate the sum to the output range
  always_comb begin
    logic signed [SAT_W-1:0] acc_ext;
    acc_ext = SAT_W'(acc);
    if (acc_ext > SAT_MAX) begin
      out_filtered_nxt = OUT_W'(SAT_MAX);
    end else if (acc_ext < SAT_MIN) begin
      out_filtered_nxt = OUT_W'(SAT_MIN);
    end else begin
      out_filtered_nxt = OUT_W'(acc_ext);
    end
  end

  // Pipeline valid bits
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_filtered_r <= out_filtered_nxt;
    end
  end

  // Capture start leaves only the new sample in the history
  a_capture_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_capture_start |=> dly_r[1] == '0 && dly_r[HIST - 1] == '0)
    else $error("delay line not cleared on capture start");

  // Newest history entry is the offset-removed sample just taken
  a_newest_tap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> dly_r[0] == $past(x))
    else $error("newest tap does not match accepted sample");

  // Accepted sample occupies the product stage next cycle
  a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted sample lost before product stage");

  // Stalled pipeline keeps both stages occupied
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r && out_valid_r)
    else $error("pipeline dropped an item during stall");

  // Band select follows configuration writes
  a_band_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> band_select_r == $past(cfg_wr_data))
    else $error("band select write not taken");

endmodule
`default_nettype wire
